>>> rtl/psht_pkg.sv
package psht_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int SLOT_IDX_W = 2;
    localparam int PRI_W      = 8;
    localparam int GEN_W      = 10;
    localparam int HANDLE_W   = 15;
    localparam int CMD_W      = 2;

    typedef logic [PRI_W-1:0]      pri_t;
    typedef logic [GEN_W-1:0]      gen_t;
    typedef logic [HANDLE_W-1:0]   handle_t;
    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_CHECK   = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    localparam gen_t    GEN_RESET      = gen_t'(1);
    localparam gen_t    GEN_MAX        = '1;
    localparam handle_t HANDLE_ALL     = '1;
    localparam handle_t HANDLE_NO_SLOT = '0;

endpackage

>>> rtl/priority_slot_handle_table_core.sv
// Four-slot generational handle table. One item is taken per cycle unless
// in_stall is high; the item is held in an input register, the slot search,
// handle check and table update are done in a single pass of short logic over
// the four slots, and the answer lands in an output register.
// The table is updated as the item moves into the output register, so the next
// item always sees the effect of the one before. in_stall rises only when both
// registers are full and out_stall is high. Allocate takes the first free slot,
// else the lowest-priority busy slot not above priority_req, and returns
// (generation << 4) | slot; it answers 0 when no slot qualifies, else -1 when
// stream_present is low. A handle of -1 on release frees every slot.
module priority_slot_handle_table_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [psht_pkg::CMD_W-1:0]    command,
    input  logic [psht_pkg::PRI_W-1:0]    priority_req,
    input  logic                          stream_present,
    input  logic signed [psht_pkg::HANDLE_W-1:0] handle,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [psht_pkg::HANDLE_W-1:0] alloc_handle,
    output logic                          handle_valid,
    output logic                          any_active
);
    import psht_pkg::*;

    // table state
    pri_t pri_reg [SLOT_COUNT];
    pri_t pri_next [SLOT_COUNT];
    gen_t gen_reg [SLOT_COUNT];
    gen_t gen_next [SLOT_COUNT];

    // input register
    logic               in_valid_reg;
    logic [CMD_W-1:0]   cmd_reg;
    pri_t               pri_req_reg;
    logic               present_reg;
    handle_t            handle_reg;

    // output register
    logic               out_valid_reg;
    handle_t            alloc_handle_reg;
    handle_t            alloc_handle_next;
    logic               handle_valid_reg;
    logic               handle_valid_next;
    logic               any_active_reg;
    logic               any_active_next;

    logic               out_load;
    logic               in_load;

    logic               free_found;
    slot_idx_t          free_idx;
    logic               best_found;
    slot_idx_t          best_idx;
    logic [PRI_W:0]     best_pri;
    logic               pick_found;
    slot_idx_t          pick_idx;
    gen_t               pick_gen;

    slot_idx_t          h_slot;
    logic               slot_ok;
    logic               match;

    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;
    assign in_load  = in_valid && !in_stall;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        best_found = 1'b0;
        best_idx   = '0;
        best_pri   = {1'b1, {PRI_W{1'b0}}};
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (pri_reg[i] == '0)
            begin
                if (!free_found)
                begin
                    free_found = 1'b1;
                    free_idx   = slot_idx_t'(i);
                end
            end
            else if (pri_reg[i] <= pri_req_reg && {1'b0, pri_reg[i]} < best_pri)
            begin
                best_found = 1'b1;
                best_idx   = slot_idx_t'(i);
                best_pri   = {1'b0, pri_reg[i]};
            end
        end
        pick_found = free_found || best_found;
        pick_idx   = free_found ? free_idx : best_idx;
        // wrap the generation from the top back to one, never through zero
        pick_gen   = (gen_reg[pick_idx] == GEN_MAX) ? GEN_RESET
                                                    : gen_reg[pick_idx] + gen_t'(1);
    end

    always_comb
    begin
        h_slot  = handle_reg[SLOT_IDX_W-1:0];
        slot_ok = {1'b0, h_slot} < (SLOT_IDX_W+1)'(SLOT_COUNT);
        match   = (handle_reg != '0) && !handle_reg[HANDLE_W-1] && slot_ok
                  && (pri_reg[h_slot] != '0)
                  && (handle_reg[GEN_W+3:4] == gen_reg[h_slot]);
    end

    always_comb
    begin
        pri_next          = pri_reg;
        gen_next          = gen_reg;
        alloc_handle_next = HANDLE_NO_SLOT;
        handle_valid_next = 1'b0;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                if (!pick_found)
                begin
                    alloc_handle_next = HANDLE_NO_SLOT;
                end
                else if (!present_reg)
                begin
                    alloc_handle_next = HANDLE_ALL;
                end
                else
                begin
                    gen_next[pick_idx] = pick_gen;
                    pri_next[pick_idx] = pri_req_reg;
                    alloc_handle_next  = {1'b0, pick_gen, 2'b00, pick_idx};
                end
            end
            CMD_CHECK:
            begin
                handle_valid_next = match;
            end
            CMD_RELEASE:
            begin
                if (handle_reg == HANDLE_ALL)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        pri_next[i] = '0;
                    end
                end
                else if (match)
                begin
                    handle_valid_next = 1'b1;
                    pri_next[h_slot]  = '0;
                end
            end
            default:
            begin
                // unused code: report activity only
                handle_valid_next = 1'b0;
            end
        endcase
        any_active_next = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (pri_next[i] != '0)
            begin
                any_active_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                pri_reg[i] <= '0;
                gen_reg[i] <= GEN_RESET;
            end
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                pri_reg       <= pri_next;
                gen_reg       <= gen_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            cmd_reg     <= command;
            pri_req_reg <= priority_req;
            present_reg <= stream_present;
            handle_reg  <= handle;
        end
        if (out_load)
        begin
            alloc_handle_reg <= alloc_handle_next;
            handle_valid_reg <= handle_valid_next;
            any_active_reg   <= any_active_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign alloc_handle = alloc_handle_reg;
    assign handle_valid = handle_valid_reg;
    assign any_active   = any_active_reg;

endmodule
